>>> src/csx_pkg.sv
// shared constants and types of the can signal extractor
`default_nettype none
package csx_pkg;
   localparam int MAX_ENTRIES = 32;
   localparam int FRAC_BITS = 16;
   localparam int PAYLOAD_BYTES = 8;
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int NUM_W = 64 + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_MAP = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_CHECK, ST_DIV, ST_FLUSH
   } csx_state_type;

   typedef struct packed {
      logic             tbl_write;
      logic             pkt_load;
      logic             tbl_read;
      logic [IDX_W-1:0] idx;
      logic             div_start;
      logic             commit;
      logic             commit_err;
      logic             flush;
   } csx_cmd_type;

   typedef struct packed {
      logic match;
      logic div_zero;
      logic div_done;
   } csx_status_type;
endpackage
`default_nettype wire

>>> src/csx_ctrl.sv
// controller: slot scan sequencer
`default_nettype none
module csx_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  wire                   req_action,
   input  csx_pkg::csx_status_type status,
   output csx_pkg::csx_cmd_type  cmd,
   output logic                  busy
);
   csx_pkg::csx_state_type state_ff, state_in;
   logic [csx_pkg::IDX_W-1:0] idx_ff, idx_in;
   localparam logic [csx_pkg::IDX_W-1:0] LAST_IDX = csx_pkg::IDX_W'(csx_pkg::MAX_ENTRIES - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csx_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      logic advance;
      advance  = 1'b0;
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.idx  = idx_ff;
      busy     = (state_ff != csx_pkg::ST_IDLE);
      unique case (state_ff)
         csx_pkg::ST_IDLE: begin
            if (start) begin
               if (req_action == csx_pkg::ACTION_WRITE) begin
                  cmd.tbl_write = 1'b1;
               end else begin
                  cmd.pkt_load = 1'b1;
                  idx_in = '0;
                  state_in = csx_pkg::ST_READ;
               end
            end
         end
         csx_pkg::ST_READ: begin
            cmd.tbl_read = 1'b1;
            state_in = csx_pkg::ST_CHECK;
         end
         csx_pkg::ST_CHECK: begin
            if (status.match) begin
               if (status.div_zero) begin
                  cmd.commit = 1'b1;
                  cmd.commit_err = 1'b1;
                  advance = 1'b1;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in = csx_pkg::ST_DIV;
               end
            end else begin
               advance = 1'b1;
            end
         end
         csx_pkg::ST_DIV: begin
            if (status.div_done) begin
               cmd.commit = 1'b1;
               advance = 1'b1;
            end
         end
         csx_pkg::ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in = csx_pkg::ST_IDLE;
         end
         default: state_in = csx_pkg::ST_IDLE;
      endcase
      if (advance) begin
         if (idx_ff == LAST_IDX) begin
            state_in = csx_pkg::ST_FLUSH;
         end else begin
            idx_in = idx_ff + 1'b1;
            state_in = csx_pkg::ST_READ;
         end
      end
   end
endmodule
`default_nettype wire

>>> src/csx_datapath.sv
// datapath: mapping table, byte gather, serial divider, result registers
`default_nettype none
module csx_datapath (
   input  wire                   clock,
   input  wire                   reset,
   input  csx_pkg::csx_cmd_type  cmd,
   output csx_pkg::csx_status_type status,
   input  wire [4:0]             req_entry_slot,
   input  wire                   req_entry_valid,
   input  wire [28:0]            req_can_id,
   input  wire [2:0]             req_first_byte,
   input  wire [2:0]             req_last_byte,
   input  wire [31:0]            req_divisor,
   input  wire [7:0]             req_signal_tag,
   input  wire [63:0]            req_payload,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_out_tag,
   output logic signed [63:0]    rsp_scaled_value,
   output logic                  rsp_divide_error,
   output logic                  rsp_saturated,
   output logic                  rsp_last
);
   typedef struct packed {
      logic [28:0] id;
      logic [2:0]  first;
      logic [2:0]  last;
      logic [31:0] divisor;
      logic [7:0]  tag;
   } entry_type;

   entry_type mem [csx_pkg::MAX_ENTRIES];
   logic [csx_pkg::MAX_ENTRIES-1:0] valid_ff;
   entry_type rd_ff;
   logic rd_valid_ff;
   logic [28:0] pkt_id_ff;
   logic [63:0] pkt_data_ff;

   logic [csx_pkg::NUM_W-1:0] num_ff;
   logic [32:0] rem_ff;
   logic [csx_pkg::CNT_W-1:0] cnt_ff;
   logic neg_ff;

   logic held_vld_ff;
   logic [7:0] held_tag_ff;
   logic [63:0] held_val_ff;
   logic held_err_ff, held_sat_ff;

   logic [8:0] slot_ext;
   assign slot_ext = 9'(req_entry_slot);

   // table write and registered read
   always_ff @(posedge clock) begin
      if (cmd.tbl_write && slot_ext < 9'(csx_pkg::MAX_ENTRIES)) begin
         mem[slot_ext[csx_pkg::IDX_W-1:0]] <= '{req_can_id, req_first_byte, req_last_byte,
                                                req_divisor, req_signal_tag};
      end
      if (cmd.tbl_read) begin
         rd_ff <= mem[cmd.idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.tbl_write && slot_ext < 9'(csx_pkg::MAX_ENTRIES)) begin
            valid_ff[slot_ext[csx_pkg::IDX_W-1:0]] <= req_entry_valid;
         end
         if (cmd.tbl_read) begin
            rd_valid_ff <= valid_ff[cmd.idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pkt_load) begin
         pkt_id_ff <= req_can_id;
         pkt_data_ff <= req_payload;
      end
   end

   assign status.match = rd_valid_ff && (rd_ff.id == pkt_id_ff);
   assign status.div_zero = (rd_ff.divisor == 32'd0);
   assign status.div_done = (cnt_ff == '0);

   // gather bytes first..last and take the magnitude
   logic [63:0] shifted, mask, raw, mag;
   logic [2:0] nb;
   always_comb begin
      shifted = pkt_data_ff >> {rd_ff.first, 3'b000};
      nb = rd_ff.last - rd_ff.first;
      mask = ~64'd0 >> {3'd7 - nb, 3'b000};
      raw = (rd_ff.first > rd_ff.last) ? 64'd0 : (shifted & mask);
      mag = raw[63] ? (64'd0 - raw) : raw;
   end

   // restoring divider, one quotient bit a cycle
   logic [32:0] rem_sh, rem_sub;
   always_comb begin
      rem_sh = {rem_ff[31:0], num_ff[csx_pkg::NUM_W-1]};
      rem_sub = rem_sh - {1'b0, rd_ff.divisor};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_start) begin
         cnt_ff <= csx_pkg::CNT_W'(csx_pkg::NUM_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         num_ff <= csx_pkg::NUM_W'(mag) << csx_pkg::FRAC_BITS;
         rem_ff <= '0;
         neg_ff <= raw[63];
      end else if (cnt_ff != '0) begin
         if (!rem_sub[32]) begin
            rem_ff <= rem_sub;
            num_ff <= {num_ff[csx_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            num_ff <= {num_ff[csx_pkg::NUM_W-2:0], 1'b0};
         end
      end
   end

   // saturate the quotient into signed 64 bits
   logic [127:0] q_wide;
   logic q_hi;
   logic [63:0] sat_val;
   logic sat_flag;
   always_comb begin
      q_wide = 128'(num_ff);
      q_hi = |q_wide[127:64];
      if (!neg_ff) begin
         sat_flag = q_hi || q_wide[63];
         sat_val = sat_flag ? 64'h7FFF_FFFF_FFFF_FFFF : q_wide[63:0];
      end else begin
         sat_flag = q_hi || (q_wide[63] && (|q_wide[62:0]));
         sat_val = sat_flag ? 64'h8000_0000_0000_0000 : (64'd0 - q_wide[63:0]);
      end
   end

   // one result held back so the final one can carry last
   always_ff @(posedge clock) begin
      if (reset) begin
         held_vld_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (cmd.commit || cmd.flush) && held_vld_ff;
         if (cmd.commit) begin
            held_vld_ff <= 1'b1;
         end else if (cmd.flush) begin
            held_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.commit || cmd.flush) && held_vld_ff) begin
         rsp_out_tag <= held_tag_ff;
         rsp_scaled_value <= held_val_ff;
         rsp_divide_error <= held_err_ff;
         rsp_saturated <= held_sat_ff;
         rsp_last <= cmd.flush;
      end
      if (cmd.commit) begin
         held_tag_ff <= rd_ff.tag;
         held_val_ff <= cmd.commit_err ? 64'd0 : sat_val;
         held_err_ff <= cmd.commit_err;
         held_sat_ff <= cmd.commit_err ? 1'b0 : sat_flag;
      end
   end

`ifndef NO_ASSERTIONS
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.commit || cmd.flush))
      else $error("result strobe without commit or flush");
   a_cnt_down: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0 && !cmd.div_start) |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("divider count skipped");
   a_last_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !held_vld_ff)
      else $error("held result left after last");
`endif
endmodule
`default_nettype wire

>>> src/can_signal_extractor_top.sv
// top level of the can signal extractor
//
// channel  | ports                 | handshake
// ---------+-----------------------+-------------------------------
// request  | start, busy, req_*    | item taken when start && !busy
// result   | rsp_valid, rsp_*      | one-cycle strobe, no back-pressure
//
// a write item is taken straight from idle; busy stays low
// a map item scans all 32 slots through the read and check states, plus
// serial division (one quotient bit a cycle over 64+16 bits) for each
// matching slot with a nonzero divisor, plus a flush of the last item
// the worst case is set by the bit-serial divider
// reset is synchronous and empties the table; results cannot be stalled
`default_nettype none
module can_signal_extractor_top (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire                req_action,
   input  wire [4:0]          req_entry_slot,
   input  wire                req_entry_valid,
   input  wire [28:0]         req_can_id,
   input  wire [2:0]          req_first_byte,
   input  wire [2:0]          req_last_byte,
   input  wire [31:0]         req_divisor,
   input  wire [7:0]          req_signal_tag,
   input  wire [63:0]         req_payload,
   output logic               rsp_valid,
   output logic [7:0]         rsp_out_tag,
   output logic signed [63:0] rsp_scaled_value,
   output logic               rsp_divide_error,
   output logic               rsp_saturated,
   output logic               rsp_last
);
   // commands from the sequencer, status back from the datapath
   csx_pkg::csx_cmd_type cmd;
   csx_pkg::csx_status_type status;

   csx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   csx_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_entry_slot   (req_entry_slot),
      .req_entry_valid  (req_entry_valid),
      .req_can_id       (req_can_id),
      .req_first_byte   (req_first_byte),
      .req_last_byte    (req_last_byte),
      .req_divisor      (req_divisor),
      .req_signal_tag   (req_signal_tag),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_divide_error (rsp_divide_error),
      .rsp_saturated    (rsp_saturated),
      .rsp_last         (rsp_last)
   );
endmodule
`default_nettype wire
